>>> hdl/kcq_pkg.sv
// shared types and constants for the key change event queue
// no dependencies
`timescale 1ns / 1ps

package kcq_pkg;

    localparam int HALF_W    = 64;
    localparam int KEY_SLOTS = 128;
    localparam int CODE_W    = 7;

    typedef struct packed {
        logic              pressed;
        logic [CODE_W-1:0] code;
    } t_event;

    typedef struct packed {
        logic   en;
        t_event ev;
    } t_push;

endpackage

>>> hdl/key_change_event_queue_core.sv
// key change detector with event queue: top level
// depends on kcq_pkg and kcq_event_fifo
// result: one per poll, loaded after the key scan, and after the pop wait state when an event pops
// throughput: one key per cycle during the scan; a poll is taken only in idle, once the last result is loaded
// the next poll is taken while a result still waits in the output register
// reset: synchronous, active low; clears the queue pointers and then sweeps the key state
// memory to zero, during which no poll is taken
`timescale 1ns / 1ps

module key_change_event_queue_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int KEY_COUNT   = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // poll channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [kcq_pkg::HALF_W-1:0] i_keys_low,
    input  logic [kcq_pkg::HALF_W-1:0] i_keys_high,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_event_valid,
    output logic                       o_event_pressed,
    output logic [kcq_pkg::CODE_W-1:0] o_event_code
);

    localparam int KW = $clog2(KEY_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_POP_WAIT
    } t_state;

    t_state r_state;

    // latched snapshot of the poll
    logic [kcq_pkg::KEY_SLOTS-1:0] r_keys;

    // scan pipeline: read stage and compare stage
    logic [kcq_pkg::CODE_W-1:0] r_rk;      // key whose state is being read
    logic                       r_issue;   // read stage active
    logic [kcq_pkg::CODE_W-1:0] r_ck;      // key being compared
    logic                       r_cv;      // compare stage active
    logic                       r_prev_q;  // registered key state read data

    // clearing sweep after reset
    logic [KW-1:0] r_clr;

    // key state memory, one bit per key
    logic r_prev_mem [KEY_COUNT];

    logic          prev_we;
    logic [KW-1:0] prev_wa;
    logic          prev_wd;
    logic          prev_re;
    logic          cur_bit;
    logic          changed;
    logic          out_free;
    logic          out_load;
    logic          fifo_empty;
    logic          fifo_pop;

    kcq_pkg::t_push  push;
    kcq_pkg::t_event pop_data;

    // output register
    logic                       r_o_valid;
    logic                       r_ev_valid;
    logic                       r_ev_pressed;
    logic [kcq_pkg::CODE_W-1:0] r_ev_code;

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_o_valid;
    assign o_event_valid   = r_ev_valid;
    assign o_event_pressed = r_ev_pressed;
    assign o_event_code    = r_ev_code;

    // the output register can be loaded when empty or being drained this cycle
    assign out_free = !r_o_valid || i_ready;

    // a result enters the output register: empty queue in pop, or popped entry in pop wait
    assign out_load = ((r_state == ST_POP) && out_free && fifo_empty)
                    || (r_state == ST_POP_WAIT);

    assign cur_bit = r_keys[r_ck];
    assign changed = r_cv && (cur_bit != r_prev_q);
    assign prev_re = (r_state == ST_SCAN) && r_issue;

    // write port: zero sweep after reset, otherwise update of a changed key
    always_comb begin
        prev_we = 1'b0;
        prev_wa = r_ck[KW-1:0];
        prev_wd = cur_bit;
        if (r_state == ST_CLEAR) begin
            prev_we = 1'b1;
            prev_wa = r_clr;
            prev_wd = 1'b0;
        end else if (r_state == ST_SCAN) begin
            prev_we = changed;
        end
    end

    // a change is queued in the same cycle its key state is written back
    always_comb begin
        push.en         = (r_state == ST_SCAN) && changed;
        push.ev.pressed = cur_bit;
        push.ev.code    = r_ck;
    end

    // pop only when the output register is free to take the entry in the following cycle
    assign fifo_pop = (r_state == ST_POP) && out_free && !fifo_empty;

    // read of key k+1 overlaps the write of key k, never the same entry
    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (prev_re) begin
            r_prev_q <= r_prev_mem[r_rk[KW-1:0]];
        end
    end

    kcq_event_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (fifo_pop),
        .o_empty    (fifo_empty),
        .o_pop_data (pop_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_issue   <= 1'b0;
            r_cv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // a new result takes the output register, otherwise a transfer frees it
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == KW'(KEY_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_keys  <= {i_keys_high, i_keys_low};
                        r_rk    <= kcq_pkg::CODE_W'(1);   // key zero is never scanned
                        r_issue <= 1'b1;
                        r_cv    <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_ck <= r_rk;
                    r_cv <= r_issue;
                    if (r_issue) begin
                        r_rk <= r_rk + 1'b1;
                        if (r_rk == kcq_pkg::CODE_W'(KEY_COUNT - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    // both stages drained: all pushes are in the queue
                    if (!r_issue && !r_cv) begin
                        r_state <= ST_POP;
                    end
                end
                ST_POP: begin
                    if (out_free) begin
                        if (fifo_empty) begin
                            r_ev_valid   <= 1'b0;
                            r_ev_pressed <= 1'b0;
                            r_ev_code    <= '0;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_state <= ST_POP_WAIT;
                        end
                    end
                end
                ST_POP_WAIT: begin
                    // output register is free here: it was empty or drained in pop
                    r_ev_valid   <= 1'b1;
                    r_ev_pressed <= pop_data.pressed;
                    r_ev_code    <= pop_data.code;
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/kcq_event_fifo.sv
// circular event queue holding at most depth-1 events, with registered read data
// depends on kcq_pkg
`timescale 1ns / 1ps

module kcq_event_fifo #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kcq_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_empty,
    output kcq_pkg::t_event o_pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    kcq_pkg::t_event r_mem [QUEUE_DEPTH];
    kcq_pkg::t_event r_q;
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;
    logic            full;

    // wrap at depth-1, depth need not be a power of two
    assign n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign full = (n_wp == r_rp);
    assign o_empty    = (r_wp == r_rp);
    assign o_pop_data = r_q;

    always_ff @(posedge i_clk) begin
        if (i_push.en && !full) begin
            r_mem[r_wp] <= i_push.ev;
        end
        if (i_pop) begin
            r_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            // a push while full is dropped
            if (i_push.en && !full) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
        end
    end

endmodule

>>> bench/testbench.sv
// self-checking bench for key_change_event_queue_core: polls go in over valid/ready, and every
// result is checked against a cycle-free predictor of the key scan and the event ring
// depends on kcq_pkg and the key change event queue rtl
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH        = 64;
    localparam int KEY_COUNT          = 128;
    localparam int PTR_W              = $clog2(QUEUE_DEPTH);
    localparam int SNAP_W             = 2 * kcq_pkg::HALF_W;
    localparam int RESULT_HOLD_CYCLES = 1500;
    localparam int SETTLE_CYCLES      = KEY_COUNT + 20;
    localparam int DRAIN_LIMIT        = 20000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [kcq_pkg::HALF_W-1:0]   i_keys_low;
    logic [kcq_pkg::HALF_W-1:0]   i_keys_high;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_event_valid;
    logic                         o_event_pressed;
    logic [kcq_pkg::CODE_W-1:0]   o_event_code;

    // predictor state: key snapshot seen last, ring of queued events and its pointers
    logic [kcq_pkg::KEY_SLOTS-1:0] key_state;
    kcq_pkg::t_event               event_ring [QUEUE_DEPTH];
    logic [PTR_W-1:0]              ring_wr;
    logic [PTR_W-1:0]              ring_rd;

    // results still owed by the block, oldest first; en carries event_valid
    kcq_pkg::t_push       pending_results [$];

    logic [SNAP_W-1:0]    last_snapshot;
    int                   polls_sent;
    int                   error_count;
    bit                   source_idles;
    bit                   sink_idles;
    bit                   result_hold_request;

    key_change_event_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_COUNT   (KEY_COUNT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_keys_low      (i_keys_low),
        .i_keys_high     (i_keys_high),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_valid   (o_event_valid),
        .o_event_pressed (o_event_pressed),
        .o_event_code    (o_event_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // scan keys 1 up to KEY_COUNT-1 in ascending order, queue each change, then pop one
    function automatic void scan_poll(input logic [SNAP_W-1:0] snap);
        kcq_pkg::t_event ev;
        kcq_pkg::t_push  res;
        int              nxt;
        for (int k = 1; k < KEY_COUNT; k++) begin
            if (snap[k] != key_state[k]) begin
                // key state follows the snapshot even when the event is dropped
                key_state[k] = snap[k];
                nxt = (int'(ring_wr) + 1) % QUEUE_DEPTH;
                if (nxt != int'(ring_rd)) begin
                    ev.pressed        = snap[k];
                    ev.code           = k[kcq_pkg::CODE_W-1:0];
                    event_ring[ring_wr] = ev;
                    ring_wr           = nxt[PTR_W-1:0];
                end
            end
        end
        // empty ring after the scan gives an all-zero result
        res = '0;
        if (ring_rd != ring_wr) begin
            res.en  = 1'b1;
            res.ev  = event_ring[ring_rd];
            nxt     = (int'(ring_rd) + 1) % QUEUE_DEPTH;
            ring_rd = nxt[PTR_W-1:0];
        end
        pending_results.push_back(res);
    endfunction

    // result checker: every transfer on the result channel against the oldest expectation
    always @(posedge i_clk) begin
        kcq_pkg::t_push exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: event_valid %0b pressed %0b code %0d",
                       o_event_valid, o_event_pressed, o_event_code);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_event_valid !== exp_res.en) begin
                    $error("event_valid: expected %0b, got %0b", exp_res.en, o_event_valid);
                    error_count++;
                end
                if (o_event_pressed !== exp_res.ev.pressed) begin
                    $error("event_pressed: expected %0b, got %0b",
                           exp_res.ev.pressed, o_event_pressed);
                    error_count++;
                end
                if (o_event_code !== exp_res.ev.code) begin
                    $error("event_code: expected %0d, got %0d", exp_res.ev.code, o_event_code);
                    error_count++;
                end
            end
        end
    end

    // result side: ready driven at the falling edge, random idle bursts, one long hold on request
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_hold_request) begin
                // long hold so the block fills its output and stops taking polls
                result_hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge i_clk);
            end else if (sink_idles && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 15);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // offer one poll at the falling edge and hold it until the transfer; valid stays high
    // on return unless an idle burst follows
    task automatic send_poll(input logic [SNAP_W-1:0] snap);
        int gap;
        i_valid     <= 1'b1;
        i_keys_low  <= snap[kcq_pkg::HALF_W-1:0];
        i_keys_high <= snap[SNAP_W-1:kcq_pkg::HALF_W];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scan_poll(snap);
        last_snapshot = snap;
        polls_sent++;
        @(negedge i_clk);
        if (source_idles && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // sender pause: withdraw valid and wait for every owed result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // last snapshot with a few random bits flipped, key zero included
    function automatic logic [SNAP_W-1:0] flip_keys(input int flips);
        logic [SNAP_W-1:0] snap;
        snap = last_snapshot;
        for (int n = 0; n < flips; n++) begin
            snap[$urandom_range(0, SNAP_W - 1)] ^= 1'b1;
        end
        return snap;
    endfunction

    // key zero never makes an event; empty ring gives the zero result
    task automatic test_key_zero();
        send_poll('0);
        send_poll(SNAP_W'(1));
        send_poll(SNAP_W'(3));
        send_poll(SNAP_W'(1));
    endtask

    // keys either side of the split between the two halves, and the top key
    task automatic test_half_boundary();
        logic [SNAP_W-1:0] snap;
        snap = '0;
        snap[kcq_pkg::HALF_W-1] = 1'b1;
        snap[kcq_pkg::HALF_W]   = 1'b1;
        snap[SNAP_W-1]          = 1'b1;
        send_poll(snap);
        send_poll('0);
        snap = '0;
        snap[1] = 1'b1;
        send_poll(snap);
    endtask

    // all keys down then all up: the ring fills and later changes are dropped
    task automatic test_ring_overflow();
        send_poll('1);
        send_poll('1);
        send_poll('0);
        send_poll('0);
        send_poll('1);
        send_poll({{kcq_pkg::HALF_W{1'b0}}, {kcq_pkg::HALF_W{1'b1}}});
        send_poll({{kcq_pkg::HALF_W{1'b1}}, {kcq_pkg::HALF_W{1'b0}}});
    endtask

    // receiver holds off for a long time while polls keep coming
    task automatic test_result_backpressure();
        result_hold_request = 1'b1;
        for (int n = 0; n < 8; n++) begin
            send_poll(flip_keys($urandom_range(1, 4)));
        end
        wait_drained();
    endtask

    // bulk traffic: bursts of many changes then quiet polls draining the ring, light typing with
    // zero to two changes per poll keeping the ring near empty, and all-ones or all-zeros polls
    task automatic test_random_traffic(input int count);
        int target;
        int mode;
        int quiet;
        target = polls_sent + count;
        while (polls_sent < target) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
                send_poll({$urandom, $urandom, $urandom, $urandom});
                quiet = $urandom_range(0, 70);
                for (int n = 0; n < quiet && polls_sent < target; n++) begin
                    send_poll(last_snapshot);
                end
            end else if (mode < 9) begin
                quiet = $urandom_range(4, 40);
                for (int n = 0; n < quiet && polls_sent < target; n++) begin
                    send_poll(flip_keys($urandom_range(0, 2)));
                end
            end else begin
                send_poll($urandom_range(0, 1) ? '1 : '0);
                if ($urandom_range(0, 1) == 0) wait_drained();
            end
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        test_random_traffic(80);
    endtask

    initial begin
        int waited;
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_keys_low          = '0;
        i_keys_high         = '0;
        key_state           = '0;
        ring_wr             = '0;
        ring_rd             = '0;
        last_snapshot       = '0;
        polls_sent          = 0;
        error_count         = 0;
        source_idles        = 1'b1;
        sink_idles          = 1'b1;
        result_hold_request = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_key_zero();
        test_half_boundary();
        test_ring_overflow();
        wait_drained();
        test_random_traffic(400);
        test_result_backpressure();
        test_random_traffic(400);
        test_steady_stream();

        // let the last results out, then give the block its latency to show anything extra
        i_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/kcq_pkg.sv
hdl/kcq_event_fifo.sv
hdl/key_change_event_queue_core.sv
bench/testbench.sv
